// ----- src/rgb_to_hsv_pixel_top_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef RGB_TO_HSV_PIXEL_TOP_MACROS_SVH
`define RGB_TO_HSV_PIXEL_TOP_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define RHSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define RHSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rhsv_pkg.sv -----
package rhsv_pkg;

    // Channel and quotient widths.
    localparam int CH_W   = 8;
    localparam int QW     = 8;
    // Hue divisor is twice delta, saturation divisor is the largest channel.
    localparam int HUE_DW = CH_W + 1;
    localparam int SAT_DW = CH_W;

    // Quotient bits resolved per divider stage.
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = QW / DIV_BPS;
    // Two front stages ahead of the divider stages.
    localparam int FRONT_STAGES = 2;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

    // Hue offsets in units of 12 degrees times delta.
    localparam logic [4:0] K_RED      = 5'd0;
    localparam logic [4:0] K_RED_WRAP = 5'd30;
    localparam logic [4:0] K_GREEN    = 5'd10;
    localparam logic [4:0] K_BLUE     = 5'd20;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // Divider operands for one pixel, plus the brightness that rides along.
    typedef struct packed {
        logic [QW+HUE_DW-1:0] hue_num;
        logic [HUE_DW-1:0]    hue_den;
        logic [QW+SAT_DW-1:0] sat_num;
        logic [SAT_DW-1:0]    sat_den;
        logic [CH_W-1:0]      bright;
    } t_div_req;

endpackage

// ----- src/rhsv_front.sv -----
module rhsv_front
    import rhsv_pkg::*;
(
    input  logic                    i_clk,
    input  logic [FRONT_STAGES-1:0] i_en,
    input  logic [CH_W-1:0]         i_red,
    input  logic [CH_W-1:0]         i_green,
    input  logic [CH_W-1:0]         i_blue,
    output t_div_req                o_req
);

    logic [CH_W-1:0]   n_mx, n_mn, r_mx, r_delta;
    logic signed [8:0] n_diff, r_diff;
    t_chan             n_sel, r_sel;

    // First stage: extremes, winning channel and the signed channel difference.
    always_comb begin
        n_mx = i_red;
        n_mn = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx) n_mx = i_blue;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn) n_mn = i_blue;
        if (i_red == n_mx) begin
            n_sel  = CH_RED;
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green == n_mx) begin
            n_sel  = CH_GREEN;
            n_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sel  = CH_BLUE;
            n_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mx    <= n_mx;
            r_delta <= n_mx - n_mn;
            r_diff  <= n_diff;
            r_sel   <= n_sel;
        end
    end

    // Second stage: hue = floor(17 * m / (2 * delta)) with m = 5 * diff + k * delta,
    // saturation = floor(255 * delta / max).
    logic [4:0]         k;
    logic [12:0]        kd;
    logic signed [13:0] diff_x, m_s;
    logic [12:0]        m;
    t_div_req           n_req;

    always_comb begin
        case (r_sel)
            CH_RED:   k = r_diff[8] ? K_RED_WRAP : K_RED;
            CH_GREEN: k = K_GREEN;
            CH_BLUE:  k = K_BLUE;
            default:  k = K_RED;
        endcase
        kd     = {8'd0, k} * {5'd0, r_delta};
        diff_x = 14'(r_diff);
        m_s    = diff_x * 14'sd5 + $signed({1'b0, kd});
        m      = m_s[12:0];

        n_req.hue_num = {4'd0, m} * 17'd17;
        // A zero divisor would give all ones; the numerator is zero then anyway.
        n_req.hue_den = (r_delta == '0) ? HUE_DW'(1) : {r_delta, 1'b0};
        n_req.sat_num = {r_delta, 8'h00} - {8'h00, r_delta};
        n_req.sat_den = (r_mx == '0) ? SAT_DW'(1) : r_mx;
        n_req.bright  = r_mx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_req <= n_req;
        end
    end

endmodule

// ----- src/rhsv_div.sv -----
module rhsv_div
    import rhsv_pkg::*;
#(
    parameter int DW = SAT_DW
)
(
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [QW+DW-1:0]      i_num,
    input  logic [DW-1:0]         i_den,
    output logic [QW-1:0]         o_quo
);

    // Restoring division, DIV_BPS quotient bits per stage. The upper numerator
    // bits are always below the divisor, so the quotient fits in QW bits.
    logic [DW-1:0] r_rem [DIV_STAGES];
    logic [QW-1:0] r_low [DIV_STAGES];
    logic [DW-1:0] r_den [DIV_STAGES];
    logic [DW-1:0] s_rem [DIV_STAGES];
    logic [QW-1:0] s_low [DIV_STAGES];
    logic [DW-1:0] s_den [DIV_STAGES];
    logic [DW-1:0] n_rem [DIV_STAGES];
    logic [QW-1:0] n_low [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign s_rem[s] = i_num[QW+DW-1:QW];
            assign s_low[s] = i_num[QW-1:0];
            assign s_den[s] = i_den;
        end else begin : g_next
            assign s_rem[s] = r_rem[s-1];
            assign s_low[s] = r_low[s-1];
            assign s_den[s] = r_den[s-1];
        end

        always_comb begin
            logic [DW:0]   t;
            logic [DW-1:0] rem;
            logic [QW-1:0] low;
            logic          qbit;
            rem = s_rem[s];
            low = s_low[s];
            for (int j = 0; j < DIV_BPS; j++) begin
                t = {rem, low[QW-1]};
                if (t >= {1'b0, s_den[s]}) begin
                    t    = t - {1'b0, s_den[s]};
                    qbit = 1'b1;
                end else begin
                    qbit = 1'b0;
                end
                rem = t[DW-1:0];
                low = {low[QW-2:0], qbit};
            end
            n_rem[s] = rem;
            n_low[s] = low;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_den[s] <= s_den[s];
            end
        end
    end

    assign o_quo = r_low[DIV_STAGES-1];

endmodule

// ----- src/rgb_to_hsv_pixel_top.sv -----
// RGB to HSV converter for 8-bit pixels, one pixel per clock while i_stall is low.
// Input channel: i_valid with i_red, i_green and i_blue; the block drives o_stall.
// A request is taken at a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid with o_hue, o_saturation and o_brightness; the receiver
// drives i_stall, and a result is taken where o_valid is high and i_stall is low.
// An accepted request enters the first of six stages: two front stages (extremes,
// then divider operands) and four divider stages that each resolve two quotient
// bits for hue and for saturation side by side.
// Throughput is one request per clock while i_stall is low; every stage then takes new data.
// Every stage carries a valid bit and moves on when it is empty or when the stage
// after it moves, so bubbles close up and requests keep entering while a finished
// result waits. o_stall rises only when all six stages hold data and the receiver
// stalls; the result on the outputs then holds steady until it is taken.
// Reset (i_rst_n low, synchronous) empties the pipeline. Black gives all zeros
// and gray pixels give hue and saturation of zero. There is no other state.
module rgb_to_hsv_pixel_top
    import rhsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [QW-1:0]   o_hue,
    output logic [QW-1:0]   o_saturation,
    output logic [CH_W-1:0] o_brightness
);

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] en;
    t_div_req               req;
    logic [CH_W-1:0]        r_bri [DIV_STAGES];

    // A stage loads when it is empty or when its contents move on.
    always_comb begin
        en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || !i_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_en    (en[FRONT_STAGES-1:0]),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_req   (req)
    );

    // Hue and saturation divide side by side under the same stage enables.
    rhsv_div #(.DW(HUE_DW)) u_hue_div (
        .i_clk (i_clk),
        .i_en  (en[PIPE_STAGES-1:FRONT_STAGES]),
        .i_num (req.hue_num),
        .i_den (req.hue_den),
        .o_quo (o_hue)
    );

    rhsv_div #(.DW(SAT_DW)) u_sat_div (
        .i_clk (i_clk),
        .i_en  (en[PIPE_STAGES-1:FRONT_STAGES]),
        .i_num (req.sat_num),
        .i_den (req.sat_den),
        .o_quo (o_saturation)
    );

    // Brightness needs no arithmetic; it follows the divider stages.
    always_ff @(posedge i_clk) begin
        if (en[FRONT_STAGES]) begin
            r_bri[0] <= req.bright;
        end
        for (int d = 1; d < DIV_STAGES; d++) begin
            if (en[FRONT_STAGES+d]) begin
                r_bri[d] <= r_bri[d-1];
            end
        end
    end

    assign o_valid      = r_vld[PIPE_STAGES-1];
    assign o_brightness = r_bri[DIV_STAGES-1];

endmodule

// ----- src/rhsv_checker.sv -----
`include "rgb_to_hsv_pixel_top_macros.svh"

module rhsv_checker
    import rhsv_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [QW-1:0]   o_hue,
    input logic [QW-1:0]   o_saturation,
    input logic [CH_W-1:0] o_brightness
);

    // Reset empties the pipeline by the next edge.
    `RHSV_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

    // Back pressure reaches the input only when a stalled result sits at the output.
    `RHSV_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "stall without cause")

    // A black pixel has no hue and no saturation.
    `RHSV_ASSERT(a_black, i_clk, i_rst_n, (o_valid && o_brightness == '0) |-> (o_hue == '0 && o_saturation == '0), "black pixel not zero")

    // Hue never reaches full scale.
    `RHSV_ASSERT(a_hue_range, i_clk, i_rst_n, o_valid |-> (o_hue != '1), "hue out of range")

    // A stalled result holds.
    `RHSV_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_hue) && $stable(o_saturation) && $stable(o_brightness)), "stalled result changed")

endmodule

bind rgb_to_hsv_pixel_top rhsv_checker u_checker (.*);
